>>> hw/rtl/ipc_pkg.sv
`default_nettype none

package ipc_pkg;

  // Default operator stack depth
  localparam int unsigned DEF_STACK_DEPTH = 32;

  // Stack entry codes
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_LPAREN = 3'd4
  } op_code_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  // ASCII characters of the expression language
  localparam logic [7:0] CHAR_AT     = 8'h40;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_ADD    = 8'h2b;
  localparam logic [7:0] CHAR_SUB    = 8'h2d;
  localparam logic [7:0] CHAR_MUL    = 8'h2a;
  localparam logic [7:0] CHAR_DIV    = 8'h2f;

  // Map a stack code back to its character
  function automatic logic [7:0] code_char(input op_code_e code);
    logic [7:0] ch;
    case (code)
      OP_ADD:  ch = CHAR_ADD;
      OP_SUB:  ch = CHAR_SUB;
      OP_MUL:  ch = CHAR_MUL;
      OP_DIV:  ch = CHAR_DIV;
      default: ch = CHAR_LPAREN;
    endcase
    return ch;
  endfunction

  // Precedence: high for multiply and divide
  function automatic logic op_prec(input op_code_e code);
    return code[1];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ipc_stack_mem.sv
`default_nettype none

module ipc_stack_mem #(
  parameter int unsigned DEPTH = ipc_pkg::DEF_STACK_DEPTH,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire ipc_pkg::op_code_e wr_code_i,
  input  wire logic [AW-1:0]     rd_top_addr_i,
  input  wire logic [AW-1:0]     rd_sec_addr_i,
  output ipc_pkg::op_code_e      rd_top_o,
  output ipc_pkg::op_code_e      rd_sec_o
);

  ipc_pkg::op_code_e mem_q [DEPTH];
  ipc_pkg::op_code_e rd_top_q;
  ipc_pkg::op_code_e rd_sec_q;

  // Write one entry, read top and second entry with registered data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_code_i;
    end
    rd_top_q <= mem_q[rd_top_addr_i];
    rd_sec_q <= mem_q[rd_sec_addr_i];
  end

  assign rd_top_o = rd_top_q;
  assign rd_sec_o = rd_sec_q;

endmodule

`default_nettype wire

>>> hw/rtl/infix_to_postfix_converter.sv
`default_nettype none

// Channel | Direction | Handshake               | Beat payload
// in      | input     | in_valid_i / in_stall_o   | in_char_i, end_of_expr_i
// out     | output    | out_valid_o / out_stall_i | out_char_o, status_o, last_of_run_o
//
// An item is accepted in idle, where the stack top is read, and acted on in eval.
// Each operator popped by ')' or by an operator adds a step in eval; the end flush
// pops one entry per step, or returns to idle for an empty stack, after the accept.
// Reset empties the stack at once; the stack memory itself needs no clearing.
// A stall on the output holds the result register and the pending work.

module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = ipc_pkg::DEF_STACK_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       end_of_expr_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_char_o,
  output logic [1:0]      status_o,
  output logic            last_of_run_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [7:0]        char_q, char_d;
  logic              end_q, end_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_char_q, out_char_d;
  ipc_pkg::status_e  status_q, status_d;
  logic              last_q, last_d;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  ipc_pkg::op_code_e wr_code;
  logic [AW-1:0]     rd_top_addr;
  logic [AW-1:0]     rd_sec_addr;
  ipc_pkg::op_code_e top_code;
  ipc_pkg::op_code_e sec_code;

  logic              out_free;
  logic              stk_empty;
  logic              stk_one;
  logic              stk_full;
  logic              is_digit;
  logic              is_op;
  ipc_pkg::op_code_e in_op;
  logic              pop_ok;
  logic              pop_last;

  // Operator stack storage
  ipc_stack_mem #(
    .DEPTH(STACK_DEPTH)
  ) u_stack_mem (
    .clk_i         (clk_i),
    .wr_en_i       (wr_en),
    .wr_addr_i     (wr_addr),
    .wr_code_i     (wr_code),
    .rd_top_addr_i (rd_top_addr),
    .rd_sec_addr_i (rd_sec_addr),
    .rd_top_o      (top_code),
    .rd_sec_o      (sec_code)
  );

  // Classify the held character
  always_comb begin
    is_digit = (char_q >= ipc_pkg::CHAR_0) && (char_q <= ipc_pkg::CHAR_9);
    is_op    = 1'b1;
    in_op    = ipc_pkg::OP_ADD;
    unique case (char_q)
      ipc_pkg::CHAR_ADD: in_op = ipc_pkg::OP_ADD;
      ipc_pkg::CHAR_SUB: in_op = ipc_pkg::OP_SUB;
      ipc_pkg::CHAR_MUL: in_op = ipc_pkg::OP_MUL;
      ipc_pkg::CHAR_DIV: in_op = ipc_pkg::OP_DIV;
      default:           is_op = 1'b0;
    endcase
  end

  // Stack status and pop decision
  assign out_free  = !out_valid_q || !out_stall_i;
  assign stk_empty = (count_q == '0);
  assign stk_one   = (count_q == CW'(1));
  assign stk_full  = (count_q == CW'(STACK_DEPTH));
  assign pop_ok    = !stk_empty && (top_code != ipc_pkg::OP_LPAREN) &&
                     (ipc_pkg::op_prec(top_code) >= ipc_pkg::op_prec(in_op));
  assign pop_last  = stk_one || (sec_code == ipc_pkg::OP_LPAREN) ||
                     (ipc_pkg::op_prec(sec_code) < ipc_pkg::op_prec(in_op));

  // Step the converter: one pop, push or result per cycle; pops and results wait while the output is stalled
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    char_d      = char_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    status_d    = status_q;
    last_d      = last_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[AW-1:0];
    wr_code     = ipc_pkg::OP_LPAREN;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          char_d  = in_char_i;
          end_d   = end_of_expr_i;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (end_q) begin
          // Flush remaining operators
          if (stk_empty) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_valid_d = 1'b1;
            if (top_code == ipc_pkg::OP_LPAREN) begin
              out_char_d = '0;
              status_d   = ipc_pkg::ST_UNMATCHED;
              last_d     = 1'b1;
              count_d    = '0;
              state_d    = ST_IDLE;
            end else begin
              out_char_d = ipc_pkg::code_char(top_code);
              status_d   = ipc_pkg::ST_OK;
              last_d     = stk_one;
              count_d    = count_q - CW'(1);
              if (stk_one) begin
                state_d = ST_IDLE;
              end
            end
          end
        end else if (is_digit) begin
          // Echo a digit
          if (out_free) begin
            out_valid_d = 1'b1;
            out_char_d  = char_q;
            status_d    = ipc_pkg::ST_OK;
            last_d      = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (char_q == ipc_pkg::CHAR_LPAREN) begin
          // Push an open parenthesis
          if (stk_full) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_char_d  = '0;
              status_d    = ipc_pkg::ST_OVERFLOW;
              last_d      = 1'b1;
              count_d     = '0;
              state_d     = ST_IDLE;
            end
          end else begin
            wr_en   = 1'b1;
            wr_code = ipc_pkg::OP_LPAREN;
            count_d = count_q + CW'(1);
            state_d = ST_IDLE;
          end
        end else if (char_q == ipc_pkg::CHAR_RPAREN) begin
          // Pop down to the matching open parenthesis
          if (stk_empty) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_char_d  = '0;
              status_d    = ipc_pkg::ST_UNMATCHED;
              last_d      = 1'b1;
              state_d     = ST_IDLE;
            end
          end else if (top_code == ipc_pkg::OP_LPAREN) begin
            count_d = count_q - CW'(1);
            state_d = ST_IDLE;
          end else if (out_free) begin
            // Mark the pop last when the matching open parenthesis sits below
            out_valid_d = 1'b1;
            out_char_d  = ipc_pkg::code_char(top_code);
            status_d    = ipc_pkg::ST_OK;
            last_d      = !stk_one && (sec_code == ipc_pkg::OP_LPAREN);
            count_d     = count_q - CW'(1);
          end
        end else if (is_op) begin
          // Pop tighter or equal operators, then push
          if (pop_ok) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_char_d  = ipc_pkg::code_char(top_code);
              status_d    = ipc_pkg::ST_OK;
              last_d      = pop_last;
              count_d     = count_q - CW'(1);
            end
          end else if (stk_full) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_char_d  = '0;
              status_d    = ipc_pkg::ST_OVERFLOW;
              last_d      = 1'b1;
              count_d     = '0;
              state_d     = ST_IDLE;
            end
          end else begin
            wr_en   = 1'b1;
            wr_code = in_op;
            count_d = count_q + CW'(1);
            state_d = ST_IDLE;
          end
        end else begin
          // Reject an invalid character
          if (out_free) begin
            out_valid_d = 1'b1;
            out_char_d  = '0;
            status_d    = ipc_pkg::ST_INVALID;
            last_d      = 1'b1;
            count_d     = '0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Read the next top and second entry; a push always passes through idle,
  // so the re-read after a write sees the new entry
  assign rd_top_addr = (count_d == '0)     ? '0 : AW'(count_d - CW'(1));
  assign rd_sec_addr = (count_d < CW'(2))  ? '0 : AW'(count_d - CW'(2));

  // Hold state, stack count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      char_q      <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      status_q    <= ipc_pkg::ST_OK;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      char_q      <= char_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      status_q    <= status_d;
      last_q      <= last_d;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

>>> hw/rtl/ipc_checker.sv
`default_nettype none

module ipc_props (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_i,
  input wire logic [7:0] in_char_i,
  input wire logic       end_of_expr_i,
  input wire logic       out_valid_i,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_char_i,
  input wire logic [1:0] status_i,
  input wire logic       last_of_run_i
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_char_i) &&
      $stable(status_i) && $stable(last_of_run_i))
    else $error("result beat changed while stalled");

  // Close the input in the cycle after each accepted beat
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input accepted on consecutive cycles");

  // Carry no character in a status result
  a_status_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ipc_pkg::ST_OK) |-> (out_char_i == 8'h00))
    else $error("status result carries a character");

  // End the run with every status result
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ipc_pkg::ST_OK) |-> last_of_run_i)
    else $error("status result not marked last");

endmodule

bind infix_to_postfix_converter ipc_props u_ipc_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_i    (in_stall_o),
  .in_char_i     (in_char_i),
  .end_of_expr_i (end_of_expr_i),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_char_i    (out_char_o),
  .status_i      (status_o),
  .last_of_run_i (last_of_run_o)
);

`default_nettype wire

>>> sim/ipc_checker.sv
`timescale 1ns / 100ps

module ipc_checker #(
  parameter int unsigned STACK_DEPTH = ipc_pkg::DEF_STACK_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_char_i,
  input  logic       end_of_expr_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_char_i,
  input  logic [1:0] status_i,
  input  logic       last_of_run_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_o,
  output int         status_results_o
);

  typedef struct packed {
    logic [7:0]       out_char;
    ipc_pkg::status_e status;
    logic             last;
  } postfix_beat_t;

  // Expected output beats, oldest first
  postfix_beat_t postfix_q [$];

  // Operator stack as seen by the predictor: holds the characters themselves
  logic [7:0] held_ops [STACK_DEPTH];
  int         held_cnt = 0;

  int fail_cnt   = 0;
  int result_cnt = 0;
  int status_cnt = 0;

  task automatic report_mismatch(input string what);
    fail_cnt++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic postfix_beat_t beat_of(input logic [7:0] ch,
                                            input ipc_pkg::status_e st);
    postfix_beat_t b;
    b.out_char = ch;
    b.status   = st;
    b.last     = 1'b0;
    return b;
  endfunction

  function automatic logic binds_tight(input logic [7:0] ch);
    return (ch == ipc_pkg::CHAR_MUL) || (ch == ipc_pkg::CHAR_DIV);
  endfunction

  function automatic logic is_arith(input logic [7:0] ch);
    return (ch == ipc_pkg::CHAR_ADD) || (ch == ipc_pkg::CHAR_SUB) || binds_tight(ch);
  endfunction

  // Work out the beats that one input beat causes and queue them
  task automatic convert_beat(input logic [7:0] ch, input logic flush);
    postfix_beat_t run [$];
    logic [7:0]    top_op;
    logic          closed;
    closed = 1'b0;
    if (flush) begin
      // drain top first, stop at an open parenthesis
      while (held_cnt > 0 && !closed) begin
        held_cnt--;
        top_op = held_ops[held_cnt];
        if (top_op == ipc_pkg::CHAR_LPAREN) begin
          run.push_back(beat_of(8'h00, ipc_pkg::ST_UNMATCHED));
          held_cnt = 0;
          closed   = 1'b1;
        end else begin
          run.push_back(beat_of(top_op, ipc_pkg::ST_OK));
        end
      end
    end else if (ch >= ipc_pkg::CHAR_0 && ch <= ipc_pkg::CHAR_9) begin
      run.push_back(beat_of(ch, ipc_pkg::ST_OK));
    end else if (ch == ipc_pkg::CHAR_RPAREN) begin
      // pop down to the matching open parenthesis and drop it
      while (held_cnt > 0 && !closed) begin
        held_cnt--;
        if (held_ops[held_cnt] == ipc_pkg::CHAR_LPAREN) closed = 1'b1;
        else run.push_back(beat_of(held_ops[held_cnt], ipc_pkg::ST_OK));
      end
      if (!closed) run.push_back(beat_of(8'h00, ipc_pkg::ST_UNMATCHED));
    end else if (ch == ipc_pkg::CHAR_LPAREN || is_arith(ch)) begin
      // an operator first pops everything that binds at least as tight
      if (ch != ipc_pkg::CHAR_LPAREN) begin
        while (held_cnt > 0 && held_ops[held_cnt-1] != ipc_pkg::CHAR_LPAREN &&
               !(binds_tight(ch) && !binds_tight(held_ops[held_cnt-1]))) begin
          held_cnt--;
          run.push_back(beat_of(held_ops[held_cnt], ipc_pkg::ST_OK));
        end
      end
      if (held_cnt >= STACK_DEPTH) begin
        run.push_back(beat_of(8'h00, ipc_pkg::ST_OVERFLOW));
        held_cnt = 0;
      end else begin
        held_ops[held_cnt] = ch;
        held_cnt++;
      end
    end else begin
      run.push_back(beat_of(8'h00, ipc_pkg::ST_INVALID));
      held_cnt = 0;
    end
    // mark the final beat of the run and queue all of them
    foreach (run[i]) begin
      if (i == run.size() - 1) run[i].last = 1'b1;
      postfix_q.push_back(run[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    postfix_beat_t want;
    if (!rst_ni) begin
      postfix_q.delete();
      held_cnt = 0;
    end else begin
      // compare a delivered beat with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        result_cnt++;
        if (status_i != ipc_pkg::ST_OK) status_cnt++;
        if (postfix_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char %h status %0d last %b",
                                    out_char_i, status_i, last_of_run_i));
        end else begin
          want = postfix_q.pop_front();
          if (out_char_i !== want.out_char)
            report_mismatch($sformatf("out_char %h, expected %h", out_char_i, want.out_char));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %s", status_i, want.status.name()));
          if (last_of_run_i !== want.last)
            report_mismatch($sformatf("last_of_run %b, expected %b", last_of_run_i, want.last));
        end
      end
      // predict the beats of an accepted input beat
      if (in_valid_i && !in_stall_i) convert_beat(in_char_i, end_of_expr_i);
    end
    fail_count_o     <= fail_cnt;
    pending_o        <= postfix_q.size();
    results_o        <= result_cnt;
    status_results_o <= status_cnt;
  end

endmodule

>>> sim/infix_to_postfix_converter_tb.sv
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;

  localparam int unsigned STACK_DEPTH = ipc_pkg::DEF_STACK_DEPTH;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 80;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_char   = 8'h00;
  logic       in_end    = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic [1:0] status;
  logic       out_last;

  int   fail_count;
  int   pending;
  int   results;
  int   status_results;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   beats_sent    = 0;
  int   quiet_cycles  = 0;
  logic hold_off_req  = 1'b0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_char_i    (in_char),
    .end_of_expr_i(in_end),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_char_o   (out_char),
    .status_o     (status),
    .last_of_run_o(out_last)
  );

  ipc_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_char_i       (in_char),
    .end_of_expr_i   (in_end),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_char_i      (out_char),
    .status_i        (status),
    .last_of_run_i   (out_last),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_o       (results),
    .status_results_o(status_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[infix_to_postfix_converter] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [7:0] ch, input logic flush);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= ch;
    in_end   <= flush;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // End beat: the character is ignored, so randomize it
  task automatic send_end();
    send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // Nest a given number of levels, which can reach and pass the stack limit
  task automatic send_deep_nest(input int levels);
    repeat (levels) send_beat(ipc_pkg::CHAR_LPAREN, 1'b0);
    send_text("1+2*3");
    repeat (levels) send_beat(ipc_pkg::CHAR_RPAREN, 1'b0);
    send_end();
  endtask

  // Build a well-formed expression, sometimes damage one character, then send it
  task automatic send_expression();
    logic [7:0] text [$];
    int         terms;
    int         open_cnt;
    int         spot;
    terms    = $urandom_range(1, 8);
    open_cnt = 0;
    for (int t = 0; t < terms; t++) begin
      while (open_cnt < 6 && $urandom_range(3) == 0) begin
        text.push_back(ipc_pkg::CHAR_LPAREN);
        open_cnt++;
      end
      text.push_back(ipc_pkg::CHAR_0 + 8'($urandom_range(9)));
      while (open_cnt > 0 && $urandom_range(2) == 0) begin
        text.push_back(ipc_pkg::CHAR_RPAREN);
        open_cnt--;
      end
      if (t < terms - 1) begin
        case ($urandom_range(3))
          0:       text.push_back(ipc_pkg::CHAR_ADD);
          1:       text.push_back(ipc_pkg::CHAR_SUB);
          2:       text.push_back(ipc_pkg::CHAR_MUL);
          default: text.push_back(ipc_pkg::CHAR_DIV);
        endcase
      end
    end
    while (open_cnt > 0) begin
      text.push_back(ipc_pkg::CHAR_RPAREN);
      open_cnt--;
    end
    // overwrite one character with any byte at all
    if ($urandom_range(99) < 15) begin
      spot       = $urandom_range(text.size() - 1);
      text[spot] = 8'($urandom_range(255));
    end
    foreach (text[i]) send_beat(text[i], 1'b0);
    // now and then carry the stack into the next expression
    if ($urandom_range(99) >= 5) send_end();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, invalid marker, digit extremes
    send_beat(8'h00, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(ipc_pkg::CHAR_AT, 1'b0);
    send_beat(ipc_pkg::CHAR_0, 1'b0);
    send_beat(ipc_pkg::CHAR_9, 1'b0);
    // every operator, both precedences, a matched pair
    send_text("(1+2)*3-4/5");
    send_end();
    // open parenthesis left at the end
    send_text("8*(");
    send_end();
    // close with no open, operator popped first
    send_text("6/)");
    // flush of an empty stack
    send_end();

    // Random phases: no idling, idle sender, stalling receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 67; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      if (ph == 0) begin
        hold_off_req = 1'b1;
        send_deep_nest(STACK_DEPTH);
      end
      while (beats_sent < 25 + (ph + 1) * ITEMS_PER_PHASE) begin
        if ($urandom_range(24) == 0) send_deep_nest($urandom_range(26, 34));
        else send_expression();
      end
    end
    in_valid <= 1'b0;

    // Drain the expected beats, then let the block settle
    stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d character and end beats under four handshake mixes and a long hold-off;",
             beats_sent);
    $display("checked %0d postfix beats, %0d of them status beats.", results, status_results);
    if (fail_count == 0 && pending == 0) begin
      $display("[infix_to_postfix_converter] OK");
    end else begin
      $display("[infix_to_postfix_converter] ERROR");
    end
    $finish;
  end

endmodule
